// ===== sv/pev_pkg.sv =====
// shared constants and width helpers for the point edge voronoi slab test
// no dependencies
package pev_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int TOL_BITS       = 16;
    localparam int QUEUE_DEPTH    = 4;

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

// ===== sv/pev_fifo.sv =====
// small register queue between the front and back parts
// depends on pev_pkg
module pev_fifo
    import pev_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output logic [WIDTH-1:0] o_pop_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp;
    logic [AW-1:0]    r_rp;
    logic [AW:0]      r_cnt;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_cnt != (AW+1)'(DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_data   = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(DEPTH))
        else $error("queue fill count beyond depth");

endmodule

// ===== sv/pev_front.sv =====
// front part: takes the query transaction and forms edge and offset vectors
// depends on pev_pkg
module pev_front
    import pev_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [3*COORD_BITS-1:0] i_query_point,
    input  logic [3*COORD_BITS-1:0] i_edge_start,
    input  logic [3*COORD_BITS-1:0] i_edge_end,
    input  logic [3*COORD_BITS-1:0] i_face_normal_one,
    input  logic [3*COORD_BITS-1:0] i_face_normal_two,
    input  logic                    i_has_two_faces,
    input  logic                    i_direction_swapped,
    output logic                    o_item_valid,
    input  logic                    i_item_ready,
    output logic [9*(COORD_BITS+1)+6*COORD_BITS+1:0] o_item
);

    localparam int C  = COORD_BITS;
    localparam int EW = C + 1;
    localparam int IW = 9*EW + 6*C + 2;

    logic          r_v;
    logic [IW-1:0] r_item;
    logic [IW-1:0] n_item;
    logic signed [EW-1:0] p [3];
    logic signed [EW-1:0] a [3];
    logic signed [EW-1:0] b [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            p[k] = EW'($signed(i_query_point[k*C +: C]));
            a[k] = EW'($signed(i_edge_start[k*C +: C]));
            b[k] = EW'($signed(i_edge_end[k*C +: C]));
        end
        n_item = '0;
        for (int k = 0; k < 3; k++) begin
            n_item[k*EW +: EW]       = b[k] - a[k];
            n_item[(3+k)*EW +: EW]   = p[k] - a[k];
            n_item[(6+k)*EW +: EW]   = p[k] - b[k];
        end
        n_item[9*EW +: 3*C]       = i_face_normal_one;
        n_item[9*EW+3*C +: 3*C]   = i_face_normal_two;
        n_item[IW-2]              = i_has_two_faces;
        n_item[IW-1]              = i_direction_swapped;
    end

    assign o_in_ready   = !r_v || i_item_ready;
    assign o_item_valid = r_v;
    assign o_item       = r_item;

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_in_ready) begin
            r_v <= i_in_valid;
        end
    end

endmodule

// ===== sv/pev_back.sv =====
// back part: projection, side plane distances and exact squared comparison
// depends on pev_pkg
module pev_back
    import pev_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [TOL_BITS-1:0] i_cfg_data,
    input  logic                i_item_valid,
    output logic                o_item_ready,
    input  logic [9*(COORD_BITS+1)+6*COORD_BITS+1:0] i_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_in_region
);

    localparam int C   = COORD_BITS;
    localparam int EW  = C + 1;
    localparam int IW  = 9*EW + 6*C + 2;
    localparam int PW  = 2*C + 4;
    localparam int HW  = 2*C + 1;
    localparam int DW  = 3*C + 3;
    localparam int QW  = 4*C + 2;
    localparam int MW  = DW - 1;
    localparam int ML  = (MW + 1) / 2;
    localparam int MH  = MW - ML;
    localparam int QL  = (QW + 1) / 2;
    localparam int QH  = QW - QL;
    localparam int TSW = 2*TOL_BITS;
    localparam int CW  = max_int(2*MW, QW + TSW) + 1;

    logic           adv;
    logic [TSW-1:0] r_tol_sq;

    // stage one
    logic                 r_v1, r_pok1, r_two1, r_swp1;
    logic signed [HW-1:0] r_c1 [2][3];
    logic signed [EW-1:0] r_da1 [3];
    logic signed [EW-1:0] e [3];
    logic signed [EW-1:0] da [3];
    logic signed [EW-1:0] db [3];
    logic signed [EW-1:0] nv [2][3];
    logic signed [PW-1:0] n_pa, n_pb;
    logic signed [HW-1:0] n_c [2][3];

    // stage two
    logic                 r_v2, r_pok2, r_two2, r_swp2;
    logic signed [DW-1:0] r_d2 [2];
    logic [QW-1:0]        r_h2 [2];
    logic signed [DW-1:0] n_d [2];
    logic signed [QW:0]   n_h [2];

    // stage three
    logic                  r_v3, r_pok3, r_two3;
    logic                  r_bh3 [2];
    logic [2*MH-1:0]       r_mhh [2];
    logic [MH+ML-1:0]      r_mhl [2];
    logic [2*ML-1:0]       r_mll [2];
    logic [QH+TSW-1:0]     r_th [2];
    logic [QL+TSW-1:0]     r_tl [2];
    logic                  n_bh [2];
    logic [MW-1:0]         n_m [2];

    // stage four, output register
    logic          r_v4, r_res;
    logic [CW-1:0] n_dsq [2];
    logic [CW-1:0] n_tq [2];
    logic          n_fail [2];

    assign adv          = !r_v4 || i_out_ready;
    assign o_item_ready = adv;
    assign o_out_valid  = r_v4;
    assign o_in_region  = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol_sq <= '0;
        end else if (i_cfg_we) begin
            r_tol_sq <= TSW'(i_cfg_data) * TSW'(i_cfg_data);
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            e[k]     = $signed(i_item[k*EW +: EW]);
            da[k]    = $signed(i_item[(3+k)*EW +: EW]);
            db[k]    = $signed(i_item[(6+k)*EW +: EW]);
            nv[0][k] = EW'($signed(i_item[9*EW + k*C +: C]));
            nv[1][k] = EW'($signed(i_item[9*EW + 3*C + k*C +: C]));
        end
        n_pa = '0;
        n_pb = '0;
        for (int k = 0; k < 3; k++) begin
            n_pa = n_pa + PW'(e[k]) * PW'(da[k]);
            n_pb = n_pb + PW'(e[k]) * PW'(db[k]);
        end
        for (int f = 0; f < 2; f++) begin
            n_c[f][0] = HW'(e[1]) * HW'(nv[f][2]) - HW'(e[2]) * HW'(nv[f][1]);
            n_c[f][1] = HW'(e[2]) * HW'(nv[f][0]) - HW'(e[0]) * HW'(nv[f][2]);
            n_c[f][2] = HW'(e[0]) * HW'(nv[f][1]) - HW'(e[1]) * HW'(nv[f][0]);
        end
    end

    always_comb begin
        for (int f = 0; f < 2; f++) begin
            n_d[f] = '0;
            n_h[f] = '0;
            for (int k = 0; k < 3; k++) begin
                n_d[f] = n_d[f] + DW'(r_c1[f][k]) * DW'(r_da1[k]);
                n_h[f] = n_h[f] + (QW+1)'(r_c1[f][k]) * (QW+1)'(r_c1[f][k]);
            end
        end
    end

    // face one is behind when its signed distance opposes the edge sense,
    // face two uses the opposite sense
    always_comb begin
        n_bh[0] = r_swp2 ? (r_d2[0] > 0) : (r_d2[0] < 0);
        n_bh[1] = r_swp2 ? (r_d2[1] < 0) : (r_d2[1] > 0);
        for (int f = 0; f < 2; f++) begin
            n_m[f] = r_d2[f][DW-1] ? MW'(-r_d2[f]) : MW'(r_d2[f]);
        end
    end

    always_comb begin
        for (int f = 0; f < 2; f++) begin
            n_dsq[f] = (CW'(r_mhh[f]) << (2*ML)) + (CW'(r_mhl[f]) << (ML + 1))
                     + CW'(r_mll[f]);
            n_tq[f]  = (CW'(r_th[f]) << QL) + CW'(r_tl[f]);
            n_fail[f] = r_bh3[f] && (n_dsq[f] > n_tq[f]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pok1 <= !(n_pa < 0) && !(n_pb > 0);
            r_two1 <= i_item[IW-2];
            r_swp1 <= i_item[IW-1];
            r_c1   <= n_c;
            r_da1  <= da;

            r_pok2 <= r_pok1;
            r_two2 <= r_two1;
            r_swp2 <= r_swp1;
            r_d2   <= n_d;
            for (int f = 0; f < 2; f++) begin
                r_h2[f] <= n_h[f][QW-1:0];
            end

            r_pok3 <= r_pok2;
            r_two3 <= r_two2;
            r_bh3  <= n_bh;
            for (int f = 0; f < 2; f++) begin
                r_mhh[f] <= (2*MH)'(n_m[f][MW-1:ML]) * (2*MH)'(n_m[f][MW-1:ML]);
                r_mhl[f] <= (MH+ML)'(n_m[f][MW-1:ML]) * (MH+ML)'(n_m[f][ML-1:0]);
                r_mll[f] <= (2*ML)'(n_m[f][ML-1:0]) * (2*ML)'(n_m[f][ML-1:0]);
                r_th[f]  <= (QH+TSW)'(r_h2[f][QW-1:QL]) * (QH+TSW)'(r_tol_sq);
                r_tl[f]  <= (QL+TSW)'(r_h2[f][QL-1:0]) * (QL+TSW)'(r_tol_sq);
            end

            r_res <= r_pok3 && !n_fail[0] && !(r_two3 && n_fail[1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_item_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    a_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && adv) |=> r_v2)
        else $error("transaction lost between stages one and two");

    a_out_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_v4) |-> $past(r_v3))
        else $error("result without transaction in stage three");

    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> ($stable(r_v3) && $stable(r_res)))
        else $error("pipeline moved while stalled");

endmodule

// ===== sv/point_edge_voronoi_test.sv =====
// Point in edge Voronoi slab test. Each transaction carries a query point, the
// edge endpoints and one or two face normals as packed signed fixed point; the
// result is one bit. One transaction is taken per cycle while the queue has room;
// a result passes through the front register, the queue and four arithmetic
// stages. A four-entry queue lets the front keep taking input while the output
// is stalled. The tolerance written on the configuration port applies from the
// next cycle onwards.
// depends on pev_pkg, pev_front, pev_fifo, pev_back
module point_edge_voronoi_test
    import pev_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [TOL_BITS-1:0]     i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [3*COORD_BITS-1:0] i_query_point,
    input  logic [3*COORD_BITS-1:0] i_edge_start,
    input  logic [3*COORD_BITS-1:0] i_edge_end,
    input  logic [3*COORD_BITS-1:0] i_face_normal_one,
    input  logic [3*COORD_BITS-1:0] i_face_normal_two,
    input  logic                    i_has_two_faces,
    input  logic                    i_direction_swapped,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic                    o_in_region
);

    localparam int IW = 9*(COORD_BITS+1) + 6*COORD_BITS + 2;

    logic          f_valid, f_ready, b_valid, b_ready;
    logic [IW-1:0] f_item, b_item;

    pev_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_query_point       (i_query_point),
        .i_edge_start        (i_edge_start),
        .i_edge_end          (i_edge_end),
        .i_face_normal_one   (i_face_normal_one),
        .i_face_normal_two   (i_face_normal_two),
        .i_has_two_faces     (i_has_two_faces),
        .i_direction_swapped (i_direction_swapped),
        .o_item_valid        (f_valid),
        .i_item_ready        (f_ready),
        .o_item              (f_item)
    );

    pev_fifo #(.WIDTH(IW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_data  (f_item),
        .o_pop_valid  (b_valid),
        .i_pop_ready  (b_ready),
        .o_pop_data   (b_item)
    );

    pev_back #(.COORD_BITS(COORD_BITS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_item_valid (b_valid),
        .o_item_ready (b_ready),
        .i_item       (b_item),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_in_region  (o_in_region)
    );

endmodule

// ===== test/point_edge_voronoi_test_tb.sv =====
// self-checking bench for point_edge_voronoi_test: slab predictor in a scoreboard
// class, directed and random queries, tolerance changes between phases
// depends on pev_pkg and point_edge_voronoi_test
`timescale 1ns / 1ps

module point_edge_voronoi_test_tb;
    import pev_pkg::*;

    localparam int CB = 16;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 12;

    typedef logic [3*CB-1:0] vec_t;
    typedef logic signed [127:0] wide_t;

    class slab_scoreboard;
        bit            expected_q[$];
        logic [15:0]   tolerance;
        int            errors;
        int            checked;
        int            inside_count;

        function new();
            tolerance = '0;
        endfunction

        function longint coord(vec_t v, int k);
            logic signed [CB-1:0] c;
            c = v[k*CB +: CB];
            return longint'(c);
        endfunction

        function bit side_clear(longint h[3], longint d[3]);
            wide_t dot, h2, hw, dw, tt;
            dot = 0;
            h2 = 0;
            for (int k = 0; k < 3; k++) begin
                hw = h[k];
                dw = d[k];
                dot += hw * dw;
                h2 += hw * hw;
            end
            if (dot >= 0) return 1'b1;
            dot = -dot;
            tt = tolerance * tolerance;
            return (dot * dot) <= (tt * h2);
        endfunction

        function bit in_slab(vec_t p, vec_t a, vec_t b, vec_t n1, vec_t n2,
                             bit two, bit swapped);
            longint e[3], da[3], h[3], nv[3], mv[3];
            longint proj_a, proj_b;
            proj_a = 0;
            proj_b = 0;
            for (int k = 0; k < 3; k++) begin
                e[k] = coord(b, k) - coord(a, k);
                da[k] = coord(p, k) - coord(a, k);
                proj_a += e[k] * da[k];
                proj_b += e[k] * (coord(p, k) - coord(b, k));
                nv[k] = coord(n1, k);
                mv[k] = coord(n2, k);
            end
            if (proj_a < 0 || proj_b > 0) return 1'b0;
            if (swapped) for (int k = 0; k < 3; k++) e[k] = -e[k];
            h[0] = e[1] * nv[2] - e[2] * nv[1];
            h[1] = e[2] * nv[0] - e[0] * nv[2];
            h[2] = e[0] * nv[1] - e[1] * nv[0];
            if (!side_clear(h, da)) return 1'b0;
            if (two) begin
                h[0] = -(e[1] * mv[2] - e[2] * mv[1]);
                h[1] = -(e[2] * mv[0] - e[0] * mv[2]);
                h[2] = -(e[0] * mv[1] - e[1] * mv[0]);
                if (!side_clear(h, da)) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_query(vec_t p, vec_t a, vec_t b, vec_t n1, vec_t n2,
                                 bit two, bit swapped);
            expected_q.push_back(in_slab(p, a, b, n1, n2, two, swapped));
        endfunction

        function void check_result(bit got);
            bit want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0b", $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got) inside_count++;
            if (got !== want) begin
                $display("%0t: in_region mismatch, expected %0b, actual %0b",
                         $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic i_clk, i_rst_n;
    logic i_cfg_we;
    logic [TOL_BITS-1:0] i_cfg_data;
    logic i_in_valid, o_in_ready;
    vec_t i_query_point, i_edge_start, i_edge_end, i_face_normal_one, i_face_normal_two;
    logic i_has_two_faces, i_direction_swapped;
    logic o_out_valid, i_out_ready, o_in_region;

    slab_scoreboard sb = new();
    int send_idle_pct, recv_idle_pct;
    int stall_cycles;
    int sent;

    point_edge_voronoi_test #(.COORD_BITS(CB)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_query_point(i_query_point), .i_edge_start(i_edge_start),
        .i_edge_end(i_edge_end), .i_face_normal_one(i_face_normal_one),
        .i_face_normal_two(i_face_normal_two), .i_has_two_faces(i_has_two_faces),
        .i_direction_swapped(i_direction_swapped),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_in_region(o_in_region)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // accepted transactions on both sides, sampled before the edge updates
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready)
            sb.note_query(i_query_point, i_edge_start, i_edge_end, i_face_normal_one,
                          i_face_normal_two, i_has_two_faces, i_direction_swapped);
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_in_region);
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (!i_in_valid && sb.expected_q.size() == 0))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("point_edge_voronoi_test verification failed");
            $finish;
        end
    end

    function automatic vec_t pack3(longint x, longint y, longint z);
        logic [CB-1:0] cx, cy, cz;
        cx = x[CB-1:0];
        cy = y[CB-1:0];
        cz = z[CB-1:0];
        return {cz, cy, cx};
    endfunction

    task automatic send_query(vec_t p, vec_t a, vec_t b, vec_t n1, vec_t n2,
                              bit two, bit swapped);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 6) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_query_point <= p;
        i_edge_start <= a;
        i_edge_end <= b;
        i_face_normal_one <= n1;
        i_face_normal_two <= n2;
        i_has_two_faces <= two;
        i_direction_swapped <= swapped;
        @(posedge i_clk);
        while (!(i_in_valid && o_in_ready)) @(posedge i_clk);
        sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_tolerance(logic [15:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.tolerance = v;
    endtask

    task automatic random_query();
        longint a[3], b[3], p[3];
        int t;
        vec_t n1, n2;
        if ($urandom_range(99) < 25) begin
            send_query(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                       48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                       48'({$urandom, $urandom}), 1'($urandom), 1'($urandom));
            return;
        end
        // point close to the edge so the projection and side tests both matter
        t = $urandom_range(280) - 12;
        for (int k = 0; k < 3; k++) begin
            a[k] = longint'($urandom_range(8000)) - 4000;
            b[k] = a[k] + longint'($urandom_range(4000)) - 2000;
            p[k] = a[k] + ((b[k] - a[k]) * t) / 256 + longint'($urandom_range(600)) - 300;
        end
        n1 = pack3(longint'($urandom_range(512)) - 256, longint'($urandom_range(512)) - 256,
                   longint'($urandom_range(512)) - 256);
        n2 = pack3(longint'($urandom_range(512)) - 256, longint'($urandom_range(512)) - 256,
                   longint'($urandom_range(512)) - 256);
        send_query(pack3(p[0], p[1], p[2]), pack3(a[0], a[1], a[2]), pack3(b[0], b[1], b[2]),
                   n1, n2, 1'($urandom), 1'($urandom));
    endtask

    task automatic directed_queries();
        vec_t a, b, nz, ny, mx, mn;
        a = pack3(0, 0, 0);
        b = pack3(2560, 0, 0);
        nz = pack3(0, 0, 256);
        ny = pack3(0, 256, 0);
        mx = {3{16'h7fff}};
        mn = {3{16'h8000}};
        // zero-length edge
        send_query(pack3(100, 200, 300), a, a, nz, ny, 1, 0);
        // endpoints and just beyond them
        send_query(a, a, b, nz, ny, 1, 0);
        send_query(b, a, b, nz, ny, 1, 1);
        send_query(pack3(-1, 0, 0), a, b, nz, ny, 0, 0);
        send_query(pack3(2561, 0, 0), a, b, nz, ny, 0, 0);
        // either side of the side planes, both directions
        send_query(pack3(1000, 10, 0), a, b, nz, ny, 0, 0);
        send_query(pack3(1000, -10, 0), a, b, nz, ny, 0, 0);
        send_query(pack3(1000, -10, 0), a, b, nz, ny, 0, 1);
        send_query(pack3(1000, 10, -10), a, b, nz, ny, 1, 0);
        send_query(pack3(1000, -10, 10), a, b, nz, ny, 1, 1);
        // degenerate normals: zero and parallel to the edge
        send_query(pack3(1000, -50, -50), a, b, pack3(0, 0, 0), pack3(256, 0, 0), 1, 0);
        // non-unit normal, second face ignored when single
        send_query(pack3(1000, -10, 0), a, b, pack3(0, 0, 5000), mn, 0, 0);
        // extreme fields
        send_query(mx, mn, mx, mx, mn, 1, 0);
        send_query(mn, mx, mn, mn, mx, 1, 1);
        send_query(mx, mx, mn, mn, mn, 0, 1);
        send_query({48{1'b0}}, mn, mx, {48{1'b1}}, mx, 1, 0);
        send_query({48{1'b1}}, {48{1'b1}}, {48{1'b0}}, mx, {48{1'b1}}, 1, 1);
    endtask

    logic [15:0] tol_plan[6];

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_out_ready = 1'b0;
        i_query_point = '0;
        i_edge_start = '0;
        i_edge_end = '0;
        i_face_normal_one = '0;
        i_face_normal_two = '0;
        i_has_two_faces = 1'b0;
        i_direction_swapped = 1'b0;
        stall_cycles = 0;
        sent = 0;
        send_idle_pct = 28;
        recv_idle_pct = 45;
        tol_plan = '{16'd0, 16'hffff, 16'd256, 16'($urandom), 16'd1, 16'($urandom_range(4096))};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        directed_queries();
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            send_idle_pct = (ph < 2) ? 28 : (ph < 4) ? 45 : 0;
            recv_idle_pct = (ph < 2) ? 45 : (ph < 4) ? 28 : 0;
            set_tolerance(tol_plan[ph]);
            for (int n = 0; n < 205; n++) begin
                if (ph == 2 && n == 100) drain();
                random_query();
            end
        end
        drain();
        $display("%0d queries sent, %0d results checked, %0d inside the slab",
                 sent, sb.checked, sb.inside_count);
        $display("six tolerance settings including zero and full scale, three idle patterns");
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("point_edge_voronoi_test verification clean");
        end else begin
            $display("point_edge_voronoi_test verification failed");
        end
        $finish;
    end

endmodule
